@@ rtl/core/ptrq_pkg.sv @@
// ptrq_pkg: shared constants, codes, state type and control structs of the
// priority task ready-queue unit. No dependencies.
package ptrq_pkg;

  localparam int MAX_TASKS_DEF  = 16;
  localparam int NUM_LEVELS_DEF = 8;
  localparam int KEY_WIDTH_DEF  = 32;

  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 3;
  localparam int DATA_W   = 32;
  localparam int PRIO_W   = 4;
  localparam int SLOT_W   = 4;

  localparam logic [DATA_W-1:0] ARG_ALL_ONES = '1;

  localparam logic [OPCODE_W-1:0] OP_REGISTER = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POST     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_CANCEL   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP      = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_QUERY    = 3'd4;

  localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STS_ALREADY  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_NOT_REG  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_BAD_PRIO = 3'd3;
  localparam logic [STATUS_W-1:0] STS_NO_FREE  = 3'd4;
  localparam logic [STATUS_W-1:0] STS_FULL     = 3'd5;
  localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FIND,
    ST_RUN1,
    ST_RUN2,
    ST_SHIFT,
    ST_LEVEL,
    ST_ENQ,
    ST_UNLINK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                load;
    logic                clr_r;
    logic                inc_r;
    logic                set_r0;
    logic                r_to_r0;
    logic                shift_start;
    logic                shift_step;
    logic                insert;
    logic                lv_clr;
    logic                lv_inc;
    logic                latch_s;
    logic                s_from_head;
    logic                enqueue;
    logic                unlink;
    logic                pop_out;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                query_hit;
    logic                slot_from_s;
    logic                publish;
  } cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                allow;
    logic                full;
    logic                prio_bad;
    logic                r_end;
    logic                key_eq;
    logic                same_next;
    logic                arg_eq;
    logic                queued_r;
    logic                r_is_r0;
    logic                shift_go;
    logic                lv_end;
    logic                head_ok;
    logic                out_busy;
  } dp_status_t;

endpackage

@@ rtl/core/ptrq_if.sv @@
// ptrq_req_if and ptrq_rsp_if: valid/ready channels for requests and results.
// Depends on ptrq_pkg for field widths.
interface ptrq_req_if;
  logic                          valid;
  logic                          ready;
  logic [ptrq_pkg::OPCODE_W-1:0] opcode;
  logic [ptrq_pkg::DATA_W-1:0]   task_key;
  logic [ptrq_pkg::DATA_W-1:0]   task_argument;
  logic [ptrq_pkg::PRIO_W-1:0]   request_priority;
  logic                          allow_duplicate;

  modport source (output valid, opcode, task_key, task_argument, request_priority,
                  allow_duplicate, input ready);
  modport sink (input valid, opcode, task_key, task_argument, request_priority,
                allow_duplicate, output ready);
endinterface

interface ptrq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ptrq_pkg::STATUS_W-1:0] status;
  logic                          scheduled_flag;
  logic [ptrq_pkg::DATA_W-1:0]   popped_key;
  logic [ptrq_pkg::DATA_W-1:0]   popped_argument;
  logic [ptrq_pkg::SLOT_W-1:0]   slot_number;

  modport source (output valid, status, scheduled_flag, popped_key, popped_argument,
                  slot_number, input ready);
  modport sink (input valid, status, scheduled_flag, popped_key, popped_argument,
                slot_number, output ready);
endinterface

@@ rtl/core/ptrq_dp.sv @@
// ptrq_dp: slot table, sorted rank list, per-level linked fifos, counters and
// result register. Depends on ptrq_pkg and the channel interfaces.
module ptrq_dp #(
  parameter int MAX_TASKS  = ptrq_pkg::MAX_TASKS_DEF,
  parameter int NUM_LEVELS = ptrq_pkg::NUM_LEVELS_DEF,
  parameter int KEY_WIDTH  = ptrq_pkg::KEY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  ptrq_req_if.sink            req_ch,
  ptrq_rsp_if.source          rsp_ch,
  input  ptrq_pkg::cmd_t      cmd,
  output ptrq_pkg::dp_status_t st
);

  localparam int KB  = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam int IW  = $clog2(MAX_TASKS);
  localparam int SW  = $clog2(MAX_TASKS + 1);
  localparam int RW  = SW;
  localparam int LW  = $clog2(NUM_LEVELS + 1);
  localparam int LIW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam logic [SW-1:0] NONE_MARK    = SW'(MAX_TASKS);
  localparam logic [LW-1:0] UNSCHED_MARK = LW'(NUM_LEVELS);

  logic [KB-1:0]               key_store [MAX_TASKS];
  logic [ptrq_pkg::DATA_W-1:0] arg_store [MAX_TASKS];
  logic [IW-1:0]               order     [MAX_TASKS];
  logic [LW-1:0]               level     [MAX_TASKS];
  logic [SW-1:0]               next_link [MAX_TASKS];
  logic [SW-1:0]               prev_link [MAX_TASKS];
  logic [SW-1:0]               head      [NUM_LEVELS];
  logic [SW-1:0]               tail      [NUM_LEVELS];
  logic [RW-1:0]               count;

  logic [ptrq_pkg::OPCODE_W-1:0] op_q;
  logic [KB-1:0]                 key_q;
  logic [ptrq_pkg::DATA_W-1:0]   arg_q;
  logic [ptrq_pkg::PRIO_W-1:0]   prio_q;
  logic                          allow_q;
  logic [RW-1:0]                 r;
  logic [RW-1:0]                 r0;
  logic [LW-1:0]                 lv;
  logic [IW-1:0]                 s_q;

  logic [ptrq_pkg::STATUS_W-1:0] res_status;
  logic                          res_flag;
  logic [ptrq_pkg::SLOT_W-1:0]   res_slot;
  logic [ptrq_pkg::DATA_W-1:0]   res_pkey;
  logic [ptrq_pkg::DATA_W-1:0]   res_parg;
  logic                          out_valid;

  logic [RW:0]    rp1;
  logic [RW-1:0]  rm1;
  logic [IW-1:0]  ord_r, ord_n, ord_m, cnt_i;
  logic [KB-1:0]  key_r, key_n, key_m;
  logic [LIW-1:0] lv_i, prio_i, ulv_i;
  logic [SW-1:0]  enq_t, ul_p, ul_n;
  logic [LW-1:0]  ul_lv;

  function automatic logic [ptrq_pkg::SLOT_W-1:0] slot4(input logic [IW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[ptrq_pkg::SLOT_W-1:0];
  endfunction

  assign rp1    = {1'b0, r} + 1'b1;
  assign rm1    = r - 1'b1;
  assign ord_r  = order[r[IW-1:0]];
  assign ord_n  = order[rp1[IW-1:0]];
  assign ord_m  = order[rm1[IW-1:0]];
  assign key_r  = key_store[ord_r];
  assign key_n  = key_store[ord_n];
  assign key_m  = key_store[ord_m];
  assign cnt_i  = count[IW-1:0];
  assign lv_i   = lv[LIW-1:0];
  assign prio_i = prio_q[LIW-1:0];
  assign enq_t  = tail[prio_i];
  assign ul_lv  = level[s_q];
  assign ulv_i  = ul_lv[LIW-1:0];
  assign ul_p   = prev_link[s_q];
  assign ul_n   = next_link[s_q];

  assign req_ch.ready = cmd.load;

  always_comb begin
    st.op        = op_q;
    st.allow     = allow_q;
    st.full      = count >= RW'(MAX_TASKS);
    st.prio_bad  = {1'b0, prio_q} >= 5'(NUM_LEVELS);
    st.r_end     = r >= count;
    st.key_eq    = key_r == key_q;
    st.same_next = (rp1 < {1'b0, count}) && (key_r == key_n);
    st.arg_eq    = arg_store[ord_r] == arg_q;
    st.queued_r  = level[ord_r] < UNSCHED_MARK;
    st.r_is_r0   = r == r0;
    st.shift_go  = (r != '0) && !(key_m < key_q);
    st.lv_end    = lv >= LW'(NUM_LEVELS);
    st.head_ok   = head[lv_i] < NONE_MARK;
    st.out_busy  = out_valid && !rsp_ch.ready;
  end

  // request capture, walk counters and the tables without reset
  always_ff @(posedge clk) begin
    if (cmd.load && req_ch.valid) begin
      op_q    <= req_ch.opcode;
      key_q   <= req_ch.task_key[KB-1:0];
      arg_q   <= req_ch.task_argument;
      prio_q  <= req_ch.request_priority;
      allow_q <= req_ch.allow_duplicate;
    end
    if (cmd.clr_r) r <= '0;
    if (cmd.inc_r) r <= rp1[RW-1:0];
    if (cmd.set_r0) r0 <= r;
    if (cmd.r_to_r0) r <= r0;
    if (cmd.shift_start) r <= count;
    if (cmd.shift_step) begin
      order[r[IW-1:0]] <= ord_m;
      r <= rm1;
    end
    if (cmd.insert) begin
      order[r[IW-1:0]] <= cnt_i;
      key_store[cnt_i] <= key_q;
      arg_store[cnt_i] <= ptrq_pkg::ARG_ALL_ONES;
    end
    if (cmd.lv_clr) lv <= '0;
    if (cmd.lv_inc) lv <= lv + 1'b1;
    if (cmd.latch_s) s_q <= ord_r;
    if (cmd.s_from_head) s_q <= head[lv_i][IW-1:0];
    if (cmd.enqueue) arg_store[s_q] <= arg_q;

    if (cmd.load) begin
      res_status <= ptrq_pkg::STS_OK;
      res_flag   <= 1'b0;
      res_slot   <= '0;
      res_pkey   <= '0;
      res_parg   <= '0;
    end
    if (cmd.set_status) res_status <= cmd.status_code;
    if (cmd.query_hit) begin
      res_flag <= st.queued_r;
      res_slot <= slot4(ord_r);
    end
    if (cmd.slot_from_s) res_slot <= slot4(s_q);
    if (cmd.insert) res_slot <= slot4(cnt_i);
    if (cmd.pop_out) begin
      res_pkey <= 32'(key_store[s_q]);
      res_parg <= arg_store[s_q];
    end
    if (cmd.publish) begin
      rsp_ch.status          <= res_status;
      rsp_ch.scheduled_flag  <= res_flag;
      rsp_ch.popped_key      <= res_pkey;
      rsp_ch.popped_argument <= res_parg;
      rsp_ch.slot_number     <= res_slot;
    end
  end

  // queue links, levels and count
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        level[i]     <= UNSCHED_MARK;
        next_link[i] <= NONE_MARK;
        prev_link[i] <= NONE_MARK;
      end
      for (int j = 0; j < NUM_LEVELS; j++) begin
        head[j] <= NONE_MARK;
        tail[j] <= NONE_MARK;
      end
    end else begin
      if (cmd.publish) out_valid <= 1'b1;
      else if (rsp_ch.ready) out_valid <= 1'b0;

      if (cmd.insert) begin
        level[cnt_i]     <= UNSCHED_MARK;
        next_link[cnt_i] <= NONE_MARK;
        prev_link[cnt_i] <= NONE_MARK;
        count            <= count + 1'b1;
      end
      if (cmd.enqueue) begin
        if (head[prio_i] >= NONE_MARK || enq_t >= NONE_MARK) begin
          head[prio_i]   <= SW'(s_q);
          prev_link[s_q] <= NONE_MARK;
        end else begin
          next_link[enq_t[IW-1:0]] <= SW'(s_q);
          prev_link[s_q]           <= enq_t;
        end
        next_link[s_q] <= NONE_MARK;
        tail[prio_i]   <= SW'(s_q);
        level[s_q]     <= LW'(prio_q);
      end
      if (cmd.unlink) begin
        if (ul_lv < UNSCHED_MARK) begin
          if (ul_p >= NONE_MARK) head[ulv_i] <= ul_n;
          else next_link[ul_p[IW-1:0]] <= ul_n;
          if (ul_n >= NONE_MARK) tail[ulv_i] <= ul_p;
          else prev_link[ul_n[IW-1:0]] <= ul_p;
        end
        prev_link[s_q] <= NONE_MARK;
        next_link[s_q] <= NONE_MARK;
        level[s_q]     <= UNSCHED_MARK;
      end
    end
  end

  assign rsp_ch.valid = out_valid;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= RW'(MAX_TASKS))
    else $error("slot count beyond table size");
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !(out_valid && !rsp_ch.ready))
    else $error("result overwritten while waiting");
  a_unlink_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.unlink |=> level[$past(s_q)] == UNSCHED_MARK)
    else $error("unlinked slot still scheduled");
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> count == $past(count) + 1'b1)
    else $error("register did not grow table");

endmodule

@@ rtl/core/ptrq_ctrl.sv @@
// ptrq_ctrl: sequencer that walks ranks, levels and insert shifts for each
// request. Depends on ptrq_pkg.
module ptrq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  ptrq_pkg::dp_status_t st,
  output ptrq_pkg::cmd_t       cmd
);

  ptrq_pkg::state_t state, state_next;
  logic single;

  assign single = st.r_is_r0 && !st.same_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ptrq_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ptrq_pkg::ST_IDLE: if (req_valid) state_next = ptrq_pkg::ST_DISPATCH;
      ptrq_pkg::ST_DISPATCH: begin
        priority case (st.op)
          ptrq_pkg::OP_REGISTER: begin
            if (st.full) state_next = ptrq_pkg::ST_DONE;
            else if (!st.allow) state_next = ptrq_pkg::ST_FIND;
            else state_next = ptrq_pkg::ST_SHIFT;
          end
          ptrq_pkg::OP_POST:
            state_next = st.prio_bad ? ptrq_pkg::ST_DONE : ptrq_pkg::ST_FIND;
          ptrq_pkg::OP_CANCEL, ptrq_pkg::OP_QUERY: state_next = ptrq_pkg::ST_FIND;
          ptrq_pkg::OP_POP: state_next = ptrq_pkg::ST_LEVEL;
          default: state_next = ptrq_pkg::ST_IDLE;
        endcase
      end
      ptrq_pkg::ST_FIND: begin
        if (st.r_end) begin
          state_next = (st.op == ptrq_pkg::OP_REGISTER) ? ptrq_pkg::ST_SHIFT
                                                       : ptrq_pkg::ST_DONE;
        end else if (st.key_eq) begin
          state_next = (st.op == ptrq_pkg::OP_REGISTER) ? ptrq_pkg::ST_DONE
                                                       : ptrq_pkg::ST_RUN1;
        end
      end
      ptrq_pkg::ST_RUN1: begin
        if (single || st.arg_eq) begin
          priority case (st.op)
            ptrq_pkg::OP_POST: begin
              if (st.queued_r) state_next = ptrq_pkg::ST_DONE;
              else if (single) state_next = ptrq_pkg::ST_ENQ;
              else state_next = ptrq_pkg::ST_RUN2;
            end
            ptrq_pkg::OP_CANCEL:
              state_next = st.queued_r ? ptrq_pkg::ST_UNLINK : ptrq_pkg::ST_DONE;
            default: state_next = ptrq_pkg::ST_DONE;
          endcase
        end else if (!st.same_next) begin
          state_next = (st.op == ptrq_pkg::OP_POST) ? ptrq_pkg::ST_RUN2 : ptrq_pkg::ST_DONE;
        end
      end
      ptrq_pkg::ST_RUN2: begin
        if (!st.queued_r) state_next = ptrq_pkg::ST_ENQ;
        else if (!st.same_next) state_next = ptrq_pkg::ST_DONE;
      end
      ptrq_pkg::ST_SHIFT: if (!st.shift_go) state_next = ptrq_pkg::ST_DONE;
      ptrq_pkg::ST_LEVEL: begin
        if (st.lv_end) state_next = ptrq_pkg::ST_DONE;
        else if (st.head_ok) state_next = ptrq_pkg::ST_UNLINK;
      end
      ptrq_pkg::ST_ENQ, ptrq_pkg::ST_UNLINK: state_next = ptrq_pkg::ST_DONE;
      ptrq_pkg::ST_DONE: if (!st.out_busy) state_next = ptrq_pkg::ST_IDLE;
      default: state_next = ptrq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ptrq_pkg::ST_IDLE: cmd.load = 1'b1;
      ptrq_pkg::ST_DISPATCH: begin
        priority case (st.op)
          ptrq_pkg::OP_REGISTER: begin
            if (st.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ptrq_pkg::STS_FULL;
            end else if (!st.allow) cmd.clr_r = 1'b1;
            else cmd.shift_start = 1'b1;
          end
          ptrq_pkg::OP_POST: begin
            if (st.prio_bad) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ptrq_pkg::STS_BAD_PRIO;
            end else cmd.clr_r = 1'b1;
          end
          ptrq_pkg::OP_CANCEL, ptrq_pkg::OP_QUERY: cmd.clr_r = 1'b1;
          ptrq_pkg::OP_POP: cmd.lv_clr = 1'b1;
          default: cmd = '0;
        endcase
      end
      ptrq_pkg::ST_FIND: begin
        if (st.r_end) begin
          if (st.op == ptrq_pkg::OP_REGISTER) cmd.shift_start = 1'b1;
          else begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ptrq_pkg::STS_NOT_REG;
          end
        end else if (st.key_eq) begin
          if (st.op == ptrq_pkg::OP_REGISTER) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ptrq_pkg::STS_ALREADY;
          end else cmd.set_r0 = 1'b1;
        end else cmd.inc_r = 1'b1;
      end
      ptrq_pkg::ST_RUN1: begin
        if (single || st.arg_eq) begin
          cmd.latch_s = 1'b1;
          priority case (st.op)
            ptrq_pkg::OP_POST: begin
              if (st.queued_r) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = ptrq_pkg::STS_ALREADY;
              end else if (!single) cmd.r_to_r0 = 1'b1;
            end
            ptrq_pkg::OP_CANCEL: begin
              if (!st.queued_r) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = ptrq_pkg::STS_ALREADY;
              end
            end
            default: cmd.query_hit = 1'b1;
          endcase
        end else if (!st.same_next) begin
          // no instance of the run carries this argument
          if (st.op == ptrq_pkg::OP_POST) cmd.r_to_r0 = 1'b1;
          else if (st.op == ptrq_pkg::OP_CANCEL) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ptrq_pkg::STS_ALREADY;
          end
        end else cmd.inc_r = 1'b1;
      end
      ptrq_pkg::ST_RUN2: begin
        if (!st.queued_r) cmd.latch_s = 1'b1;
        else if (!st.same_next) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ptrq_pkg::STS_NO_FREE;
        end else cmd.inc_r = 1'b1;
      end
      ptrq_pkg::ST_SHIFT: begin
        if (st.shift_go) cmd.shift_step = 1'b1;
        else cmd.insert = 1'b1;
      end
      ptrq_pkg::ST_LEVEL: begin
        if (st.lv_end) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ptrq_pkg::STS_EMPTY;
        end else if (st.head_ok) cmd.s_from_head = 1'b1;
        else cmd.lv_inc = 1'b1;
      end
      ptrq_pkg::ST_ENQ: begin
        cmd.enqueue     = 1'b1;
        cmd.slot_from_s = 1'b1;
      end
      ptrq_pkg::ST_UNLINK: begin
        cmd.unlink      = 1'b1;
        cmd.slot_from_s = 1'b1;
        cmd.pop_out     = st.op == ptrq_pkg::OP_POP;
      end
      ptrq_pkg::ST_DONE: cmd.publish = !st.out_busy;
      default: cmd = '0;
    endcase
  end

  a_publish_done: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> state == ptrq_pkg::ST_IDLE)
    else $error("publish did not end the request");
  a_one_mutation: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.enqueue, cmd.unlink, cmd.insert, cmd.shift_step}) <= 1)
    else $error("conflicting table updates");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == ptrq_pkg::ST_IDLE)
    else $error("request taken while busy");

endmodule

@@ rtl/core/priority_task_ready_queues_unit.sv @@
// priority_task_ready_queues_unit: top level of the task ready-queue unit.
// Depends on ptrq_pkg, ptrq_if, ptrq_ctrl and ptrq_dp.
//
//  channel  dir  handshake     payload
//  req_ch   in   valid/ready   opcode, task_key, task_argument, request_priority,
//                              allow_duplicate
//  rsp_ch   out  valid/ready   status, scheduled_flag, popped_key, popped_argument,
//                              slot_number
//
// one request at a time; a request is taken only in idle, and a result may
// still wait in the output register meanwhile.
// register: key search (skipped when allow_duplicate is set), then one rank
// shifted per cycle; post, cancel and query walk the ranks, and pop walks the
// levels.
// synchronous reset clears links, levels and count at once; no clearing pass.
// a stalled output holds the sequencer in its final state.
module priority_task_ready_queues_unit #(
  parameter int MAX_TASKS  = ptrq_pkg::MAX_TASKS_DEF,
  parameter int NUM_LEVELS = ptrq_pkg::NUM_LEVELS_DEF,
  parameter int KEY_WIDTH  = ptrq_pkg::KEY_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ptrq_req_if.sink   req_ch,
  ptrq_rsp_if.source rsp_ch
);

  ptrq_pkg::cmd_t       cmd;
  ptrq_pkg::dp_status_t st;

  ptrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_ch.valid),
    .st        (st),
    .cmd       (cmd)
  );

  ptrq_dp #(
    .MAX_TASKS  (MAX_TASKS),
    .NUM_LEVELS (NUM_LEVELS),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .rsp_ch (rsp_ch),
    .cmd    (cmd),
    .st     (st)
  );

endmodule
